>>> sv/slq_pkg.sv
package slq_pkg;

  localparam int unsigned PriceW  = 20;
  localparam int unsigned QtyW    = 16;
  localparam int unsigned CostW   = 53;
  localparam int unsigned StatusW = 3;

  typedef enum logic [StatusW-1:0] {
    StOk       = 3'd0,
    StFull     = 3'd1,
    StZeroQty  = 3'd2,
    StEmpty    = 3'd3,
    StShort    = 3'd4
  } status_e;

  typedef enum logic {
    ReqAdd  = 1'b0,
    ReqFill = 1'b1
  } req_e;

  typedef struct packed {
    logic              req_type;
    logic [PriceW-1:0] lot_price;
    logic [QtyW-1:0]   amount;
  } req_t;

  typedef struct packed {
    logic [CostW-1:0]   cost;
    logic [QtyW-1:0]    filled;
    logic [StatusW-1:0] status;
  } rsp_t;

  // Divider handshake between the sequencer and the divide unit.
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

>>> sv/slq_div.sv
module slq_div #(
  parameter int unsigned NumW = 36,
  parameter int unsigned DenW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;

  // One quotient bit per cycle, restoring.
  always_comb begin
    trial = {rem_q, quo_q[NumW-1]};
    diff  = trial - {1'b0, den_q};
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff[DenW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial[DenW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

>>> sv/sorted_lot_queue_greedy_fill.sv
// Sequence from the accepting edge to the result word: an add runs the divider, then the slot
//   search (StSrch and StSrchW per lot passed), then StShift to carry each later lot down (a
//   direct write when it goes at the tail) and StResp to present; a fill runs StFillRd and
//   StFillMul per lot touched, StCompact per kept lot and once more to finish when any lot drains whole, then StResp.
// Throughput: one word at a time; in_stall_o stays high until the result word is taken.
// Reset clears the lot count and the sequencer; the lot memory is not cleared.
module sorted_lot_queue_greedy_fill #(
  parameter int unsigned LOT_DEPTH = 256,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  slq_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output slq_pkg::rsp_t out_data_o
);
  localparam int unsigned UnitW = slq_pkg::PriceW + FRAC_BITS;
  localparam int unsigned AddrW = (LOT_DEPTH > 1) ? $clog2(LOT_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(LOT_DEPTH + 1);
  localparam int unsigned ProdW = UnitW + slq_pkg::QtyW;
  localparam int unsigned EntW  = UnitW + slq_pkg::QtyW;

  typedef enum logic [8:0] {
    StIdle   = 9'b000000001,
    StDiv    = 9'b000000010,
    StSrch   = 9'b000000100,
    StSrchW  = 9'b000001000,
    StShift  = 9'b000010000,
    StFillRd = 9'b000100000,
    StFillMul= 9'b001000000,
    StCompact= 9'b010000000,
    StResp   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Lot memory: unit price and remaining quantity per entry, one port each way.
  logic [EntW-1:0]  mem [LOT_DEPTH];
  logic [EntW-1:0]  rd_q;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [EntW-1:0]  wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  logic [UnitW-1:0]        rd_unit;
  logic [slq_pkg::QtyW-1:0] rd_qty;
  assign rd_unit = rd_q[EntW-1:slq_pkg::QtyW];
  assign rd_qty  = rd_q[slq_pkg::QtyW-1:0];

  logic [CntW-1:0]          count_q, count_d;
  logic [CntW-1:0]          idx_q, idx_d;     // walk pointer
  logic [CntW-1:0]          used_q, used_d;   // lots drained whole
  logic [UnitW-1:0]         unit_q, unit_d;
  logic [slq_pkg::QtyW-1:0] qty_q, qty_d;     // lot qty or open demand
  logic [slq_pkg::QtyW-1:0] dem_q, dem_d;
  logic [slq_pkg::CostW-1:0] sum_q, sum_d;
  logic [ProdW-1:0]         prod_q, prod_d;
  logic [slq_pkg::QtyW-1:0] take_q, take_d;
  logic                     out_valid_q, out_valid_d;
  slq_pkg::rsp_t            out_q, out_d;

  logic             div_start;
  logic             div_done;
  logic [UnitW-1:0] div_quo;

  slq_div #(.NumW(UnitW), .DenW(slq_pkg::QtyW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  ({in_data_i.lot_price, {FRAC_BITS{1'b0}}}),
    .den_i  (in_data_i.amount),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  logic accept;
  assign in_stall_o = (state_q != StIdle) || out_valid_q;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    used_d      = used_q;
    unit_d      = unit_q;
    qty_d       = qty_q;
    dem_d       = dem_q;
    sum_d       = sum_q;
    prod_d      = prod_q;
    take_d      = take_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_start   = 1'b0;
    rd_addr     = idx_q[AddrW-1:0];
    wr_en       = 1'b0;
    wr_addr     = idx_q[AddrW-1:0];
    wr_data     = {unit_q, qty_q};

    case (state_q)
      StIdle: begin
        if (accept) begin
          out_d = '0;
          if (in_data_i.req_type == slq_pkg::ReqAdd) begin
            if (in_data_i.amount == '0) begin
              out_d.status = slq_pkg::StZeroQty;
              state_d = StResp;
            end else if (count_q >= CntW'(LOT_DEPTH)) begin
              out_d.status = slq_pkg::StFull;
              state_d = StResp;
            end else begin
              qty_d     = in_data_i.amount;
              div_start = 1'b1;
              state_d   = StDiv;
            end
          end else begin
            dem_d   = in_data_i.amount;
            qty_d   = in_data_i.amount;
            sum_d   = '0;
            used_d  = '0;
            idx_d   = '0;
            // Fetch the head lot for the first fill step.
            rd_addr = '0;
            if (count_q == '0) begin
              out_d.status = slq_pkg::StEmpty;
              state_d = StResp;
            end else if (in_data_i.amount == '0) begin
              state_d = StResp;
            end else begin
              state_d = StFillRd;
            end
          end
        end
      end
      StDiv: begin
        if (div_done) begin
          unit_d  = div_quo;
          idx_d   = '0;
          state_d = StSrch;
        end
      end
      // Find the first lot with a strictly higher unit price.
      StSrch: begin
        if (idx_q == count_q) begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
          state_d = StResp;
        end else begin
          state_d = StSrchW;
        end
      end
      StSrchW: begin
        if (rd_unit <= unit_q) begin
          idx_d   = idx_q + 1'b1;
          state_d = StSrch;
        end else begin
          // Store the new lot here and carry the displaced one down.
          wr_en   = 1'b1;
          unit_d  = rd_unit;
          qty_d   = rd_qty;
          idx_d   = idx_q + 1'b1;
          rd_addr = idx_q[AddrW-1:0] + 1'b1;
          state_d = StShift;
        end
      end
      StShift: begin
        if (idx_q == count_q) begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
          state_d = StResp;
        end else begin
          wr_en   = 1'b1;
          unit_d  = rd_unit;
          qty_d   = rd_qty;
          idx_d   = idx_q + 1'b1;
          rd_addr = idx_q[AddrW-1:0] + 1'b1;
        end
      end
      // Fill: rd_q holds lot idx_q; take from it.
      StFillRd: begin
        if (qty_q < rd_qty) begin
          take_d = qty_q;
          wr_en  = 1'b1;
          wr_data = {rd_unit, rd_qty - qty_q};
          qty_d  = '0;
        end else begin
          take_d = rd_qty;
          qty_d  = qty_q - rd_qty;
          used_d = used_q + 1'b1;
        end
        prod_d  = ProdW'(rd_unit) * ProdW'(take_d);
        state_d = StFillMul;
      end
      StFillMul: begin
        sum_d = sum_q + slq_pkg::CostW'(prod_q);
        if (qty_q != '0 && used_q != count_q) begin
          idx_d   = used_q;
          rd_addr = used_q[AddrW-1:0];
          state_d = StFillRd;
        end else if (used_q != '0) begin
          idx_d   = '0;
          rd_addr = used_q[AddrW-1:0];
          state_d = StCompact;
        end else begin
          state_d = StResp;
        end
        out_d.cost   = sum_q + slq_pkg::CostW'(prod_q);
        out_d.filled = dem_q - qty_q;
        out_d.status = (qty_q != '0) ? slq_pkg::StShort : slq_pkg::StOk;
      end
      // Move remaining lots forward by used_q entries.
      StCompact: begin
        if (idx_q + used_q >= count_q) begin
          count_d = count_q - used_q;
          state_d = StResp;
        end else begin
          wr_en   = 1'b1;
          wr_data = rd_q;
          idx_d   = idx_q + 1'b1;
          rd_addr = AddrW'(idx_q + used_q + 1'b1);
        end
      end
      StResp: begin
        out_valid_d = 1'b1;
        state_d     = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    used_q <= used_d;
    unit_q <= unit_d;
    qty_q  <= qty_d;
    dem_q  <= dem_d;
    sum_q  <= sum_d;
    prod_q <= prod_d;
    take_q <= take_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Lot count never exceeds the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(LOT_DEPTH))
    else $error("lot count beyond depth");
  // A held result word stays put while stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("result changed under stall");
  // Drained whole lots never exceed the held count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StCompact |-> used_q <= count_q)
    else $error("drained more lots than held");
  // Quantity taken from one lot never exceeds demand.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFillMul |-> take_q <= dem_q)
    else $error("take beyond demand");
endmodule
